// File: rtl/tms_pkg.sv
// Shared constants and types for the tone melody sequencer.
package tms_pkg;

  // Timer input clock; each tone divisor is this value divided by the tone frequency.
  localparam int unsigned INPUT_CLOCK_HZ = 1193180;
  localparam int unsigned DIVIDEND_W     = $clog2(INPUT_CLOCK_HZ + 1);
  localparam int unsigned DIV_CNT_W      = $clog2(DIVIDEND_W);

  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned DUR_W    = 16;
  localparam int unsigned BDUR_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned MAX_NOTES = 64;
  localparam int unsigned NOTE_AW  = $clog2(MAX_NOTES);

  localparam logic [FREQ_W-1:0] BEEP_FREQ_RST = 16'd1000;
  localparam logic [BDUR_W-1:0] BEEP_DUR_RST  = 8'd3;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_START = 3'd2,
    CMD_STOP  = 3'd3,
    CMD_BEEP  = 3'd4
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BEEP_FREQ = 1'b0,
    REG_BEEP_DUR  = 1'b1
  } reg_idx_t;

endpackage

// File: rtl/tms_div.sv
// Restoring divider: the timer clock constant divided by a tone frequency, one bit per cycle.
module tms_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tms_pkg::FREQ_W-1:0]  den,
  output logic                        done,
  output logic [tms_pkg::FREQ_W-1:0]  quot
);

  logic                              busy_r;
  logic [tms_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [tms_pkg::DIVIDEND_W-1:0]    dvd_r;
  logic [tms_pkg::FREQ_W-1:0]        den_r;
  logic [tms_pkg::FREQ_W-1:0]        rem_r;
  logic [tms_pkg::FREQ_W-1:0]        quot_r;
  logic                              done_r;

  logic [tms_pkg::FREQ_W:0]          shifted;
  logic [tms_pkg::FREQ_W+1:0]        diff;
  logic                              qbit;

  assign shifted = {rem_r, dvd_r[tms_pkg::DIVIDEND_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign qbit    = ~diff[tms_pkg::FREQ_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tms_pkg::DIV_CNT_W'(tms_pkg::DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The quotient register is only 16 bits wide, so the upper quotient bits fall off the top.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r  <= tms_pkg::DIVIDEND_W'(tms_pkg::INPUT_CLOCK_HZ);
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[tms_pkg::DIVIDEND_W-2:0], 1'b0};
      rem_r  <= qbit ? diff[tms_pkg::FREQ_W-1:0] : shifted[tms_pkg::FREQ_W-1:0];
      quot_r <= {quot_r[tms_pkg::FREQ_W-2:0], qbit};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

// File: rtl/tone_melody_sequencer_top.sv
// Top level of the tone melody sequencer: command sequencer, note table and status output.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall  | command, slot, frequency, duration, length
//  out     | output    | out_valid / out_stall| speaker, divisor, playing, beep, position
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One command at a time: a beat that needs no table read or divide goes straight to S_DONE,
// a table read adds the S_RD and S_USE states, and a tone divide adds S_DIV (one quotient
// bit per cycle over the 21-bit timer constant).
// Reset is synchronous and active low; the note table has no reset.
// in_stall is high from acceptance until the status beat is loaded into the output
// register; a stalled output only delays that load.
module tone_melody_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_note_slot,
  input  logic [15:0] in_note_frequency,
  input  logic [15:0] in_note_duration,
  input  logic [6:0]  in_melody_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_speaker_on,
  output logic [15:0] out_tone_divisor,
  output logic        out_melody_playing,
  output logic        out_beep_active,
  output logic [6:0]  out_note_position,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_USE  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [tms_pkg::FREQ_W-1:0]       beep_freq_r;
  logic [tms_pkg::BDUR_W-1:0]       beep_dur_r;
  logic [tms_pkg::LEN_W-1:0]        len_r, len_nxt;
  logic [tms_pkg::LEN_W-1:0]        idx_r, idx_nxt;
  logic [tms_pkg::DUR_W-1:0]        ticks_r, ticks_nxt;
  logic [tms_pkg::BDUR_W-1:0]       beep_rem_r, beep_rem_nxt;
  logic                             playing_r, playing_nxt;
  logic                             gate_r, gate_nxt;
  logic [tms_pkg::FREQ_W-1:0]       divisor_r, divisor_nxt;
  logic [tms_pkg::NOTE_AW-1:0]      rd_addr_r, rd_addr_nxt;
  logic                             load_dur_r, load_dur_nxt;
  logic                             out_valid_r;

  logic [tms_pkg::FREQ_W+tms_pkg::DUR_W-1:0] note_mem [tms_pkg::MAX_NOTES];
  logic [tms_pkg::FREQ_W+tms_pkg::DUR_W-1:0] rd_data_r;
  logic [tms_pkg::FREQ_W-1:0]       rd_freq;
  logic [tms_pkg::DUR_W-1:0]        rd_dur;

  logic                             in_acc;
  logic                             out_load;
  logic                             mem_we;
  logic                             div_start;
  logic [tms_pkg::FREQ_W-1:0]       div_den;
  logic                             div_done;
  logic [tms_pkg::FREQ_W-1:0]       div_quot;
  logic [tms_pkg::LEN_W-1:0]        idx_inc;
  logic [tms_pkg::BDUR_W-1:0]       beep_dec;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign rd_freq  = rd_data_r[tms_pkg::FREQ_W+tms_pkg::DUR_W-1:tms_pkg::DUR_W];
  assign rd_dur   = rd_data_r[tms_pkg::DUR_W-1:0];
  assign idx_inc  = idx_r + 1'b1;
  assign beep_dec = beep_rem_r - 1'b1;
  assign mem_we   = in_acc && (tms_pkg::cmd_t'(in_command) == tms_pkg::CMD_WRITE);

  tms_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      note_mem[in_note_slot] <= {in_note_frequency, in_note_duration};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= note_mem[rd_addr_r];
  end

  always_comb begin
    state_nxt    = state_r;
    len_nxt      = len_r;
    idx_nxt      = idx_r;
    ticks_nxt    = ticks_r;
    beep_rem_nxt = beep_rem_r;
    playing_nxt  = playing_r;
    gate_nxt     = gate_r;
    divisor_nxt  = divisor_r;
    rd_addr_nxt  = rd_addr_r;
    load_dur_nxt = load_dur_r;
    div_start    = 1'b0;
    div_den      = rd_freq;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DONE;
          case (tms_pkg::cmd_t'(in_command))
            tms_pkg::CMD_TICK: begin
              if (beep_rem_r != '0) begin
                beep_rem_nxt = beep_dec;
                if (beep_dec == '0) begin
                  // The beep ends: silence, or bring back the current note.
                  if (!playing_r) begin
                    gate_nxt = 1'b0;
                  end else if (idx_r < len_r) begin
                    rd_addr_nxt  = idx_r[tms_pkg::NOTE_AW-1:0];
                    load_dur_nxt = 1'b0;
                    state_nxt    = S_RD;
                  end
                end
              end else if (playing_r) begin
                if (ticks_r != '0) begin
                  ticks_nxt = ticks_r - 1'b1;
                end else begin
                  idx_nxt = idx_inc;
                  if (idx_inc >= len_r) begin
                    playing_nxt = 1'b0;
                    gate_nxt    = 1'b0;
                    len_nxt     = '0;
                  end else begin
                    rd_addr_nxt  = idx_inc[tms_pkg::NOTE_AW-1:0];
                    load_dur_nxt = 1'b1;
                    state_nxt    = S_RD;
                  end
                end
              end
            end
            tms_pkg::CMD_START: begin
              if (in_melody_length != '0) begin
                if (in_melody_length > tms_pkg::LEN_W'(tms_pkg::MAX_NOTES)) begin
                  len_nxt = tms_pkg::LEN_W'(tms_pkg::MAX_NOTES);
                end else begin
                  len_nxt = in_melody_length;
                end
                idx_nxt      = '0;
                playing_nxt  = 1'b1;
                rd_addr_nxt  = '0;
                load_dur_nxt = 1'b1;
                state_nxt    = S_RD;
              end
            end
            tms_pkg::CMD_STOP: begin
              playing_nxt = 1'b0;
              gate_nxt    = 1'b0;
              len_nxt     = '0;
            end
            tms_pkg::CMD_BEEP: begin
              beep_rem_nxt = beep_dur_r;
              if (beep_freq_r != '0) begin
                div_start = 1'b1;
                div_den   = beep_freq_r;
                state_nxt = S_DIV;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_USE;
      end
      S_USE: begin
        if (load_dur_r) begin
          ticks_nxt = rd_dur;
        end
        if (rd_freq != '0) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          // A rest silences the speaker unless a beep is still sounding.
          if (beep_rem_r == '0) begin
            gate_nxt = 1'b0;
          end
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          divisor_nxt = div_quot;
          gate_nxt    = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      len_r      <= '0;
      idx_r      <= '0;
      ticks_r    <= '0;
      beep_rem_r <= '0;
      playing_r  <= 1'b0;
      gate_r     <= 1'b0;
      divisor_r  <= '0;
      rd_addr_r  <= '0;
      load_dur_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      idx_r      <= idx_nxt;
      ticks_r    <= ticks_nxt;
      beep_rem_r <= beep_rem_nxt;
      playing_r  <= playing_nxt;
      gate_r     <= gate_nxt;
      divisor_r  <= divisor_nxt;
      rd_addr_r  <= rd_addr_nxt;
      load_dur_r <= load_dur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beep_freq_r <= tms_pkg::BEEP_FREQ_RST;
      beep_dur_r  <= tms_pkg::BEEP_DUR_RST;
    end else if (cfg_we) begin
      case (tms_pkg::reg_idx_t'(cfg_index))
        tms_pkg::REG_BEEP_FREQ: beep_freq_r <= cfg_data;
        tms_pkg::REG_BEEP_DUR:  beep_dur_r  <= cfg_data[tms_pkg::BDUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speaker_on     <= gate_r;
      out_tone_divisor   <= divisor_r;
      out_melody_playing <= playing_r;
      out_beep_active    <= (beep_rem_r != '0);
      out_note_position  <= idx_r;
    end
  end

  assign out_valid = out_valid_r;

  // While a melody plays, the note index stays inside the active length.
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (idx_r < len_r))
    else $error("note index outside active melody length");

  // The divider only reports completion while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider done outside divide state");

  // An accepted beat holds off the input until its status beat is produced.
  a_accept_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after an accepted beat");

  // A status beat is loaded only when the output register can take it.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("status beat overwritten while stalled");

endmodule

// File: verif/tone_melody_sequencer_top_tb.sv
// Self-checking testbench for the tone melody sequencer top level.
`timescale 1ns / 100ps

module tone_melody_sequencer_top_tb;
  import tms_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int SETTLE_CYCLES  = 32;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 320;
  localparam int IDLE_HEAVY     = 88;
  localparam int IDLE_LIGHT     = 12;
  localparam int MAX_PRINTS     = 50;
  localparam int CMD_CODE_MAX   = (1 << $bits(cmd_t)) - 1;
  localparam int LEN_MAX        = (1 << LEN_W) - 1;
  localparam int FREQ_MAX       = (1 << FREQ_W) - 1;

  typedef struct {
    logic [2:0]         code;
    logic [NOTE_AW-1:0] slot;
    logic [FREQ_W-1:0]  freq;
    logic [DUR_W-1:0]   dur;
    logic [LEN_W-1:0]   len;
    bit                 hold;
  } seq_cmd_t;

  typedef struct packed {
    logic              speaker;
    logic [FREQ_W-1:0] divisor;
    logic              playing;
    logic              beeping;
    logic [LEN_W-1:0]  position;
  } tone_status_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        in_command = '0;
  logic [5:0]        in_note_slot = '0;
  logic [15:0]       in_note_frequency = '0;
  logic [15:0]       in_note_duration = '0;
  logic [6:0]        in_melody_length = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_speaker_on;
  logic [15:0]       out_tone_divisor;
  logic              out_melody_playing;
  logic              out_beep_active;
  logic [6:0]        out_note_position;
  logic              cfg_we = 1'b0;
  logic [0:0]        cfg_index = '0;
  logic [15:0]       cfg_data = '0;

  tone_melody_sequencer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_note_slot       (in_note_slot),
    .in_note_frequency  (in_note_frequency),
    .in_note_duration   (in_note_duration),
    .in_melody_length   (in_melody_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_speaker_on     (out_speaker_on),
    .out_tone_divisor   (out_tone_divisor),
    .out_melody_playing (out_melody_playing),
    .out_beep_active    (out_beep_active),
    .out_note_position  (out_note_position),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sequencer state as the testbench expects it.
  logic [FREQ_W-1:0] note_freq [MAX_NOTES];
  logic [DUR_W-1:0]  note_len [MAX_NOTES];
  logic [LEN_W-1:0]  melody_len = '0;
  logic [LEN_W-1:0]  note_idx = '0;
  logic [DUR_W-1:0]  ticks_left = '0;
  logic [BDUR_W-1:0] beep_left = '0;
  logic              playing = 1'b0;
  logic              gate = 1'b0;
  logic [FREQ_W-1:0] divisor = '0;
  logic [FREQ_W-1:0] beep_freq_cfg = BEEP_FREQ_RST;
  logic [BDUR_W-1:0] beep_dur_cfg = BEEP_DUR_RST;

  seq_cmd_t     pending_cmd_q [$];
  tone_status_t status_due_q [$];
  seq_cmd_t     cur_cmd;
  bit           slot_written [MAX_NOTES];
  int           phase_items = 0;
  int           items_in = 0;
  int           results_out = 0;
  int           err_count = 0;
  int           quiet_cycles = 0;
  int           snd_idle_pct = 0;
  int           rcv_stall_pct = 0;

  function automatic void tone_on(input logic [FREQ_W-1:0] f);
    if (f != 0) begin
      divisor = FREQ_W'(INPUT_CLOCK_HZ / f);
      gate = 1'b1;
    end
  endfunction

  function automatic void note_or_rest(input logic [FREQ_W-1:0] f);
    if (f == 0) begin
      gate = 1'b0;
    end else begin
      tone_on(f);
    end
  endfunction

  function automatic void silence_all();
    playing = 1'b0;
    gate = 1'b0;
    melody_len = '0;
  endfunction

  function automatic tone_status_t predict_status(input seq_cmd_t c);
    tone_status_t st;
    case (c.code)
      CMD_TICK: begin
        if (beep_left != 0) begin
          // A running beep freezes the note countdown.
          beep_left = beep_left - 1'b1;
          if (beep_left == 0) begin
            if (!playing) begin
              gate = 1'b0;
            end else if (note_idx < melody_len && note_idx < MAX_NOTES) begin
              note_or_rest(note_freq[note_idx]);
            end
          end
        end else if (playing) begin
          if (ticks_left != 0) begin
            ticks_left = ticks_left - 1'b1;
          end else begin
            note_idx = note_idx + 1'b1;
            if (note_idx >= melody_len || note_idx >= MAX_NOTES) begin
              silence_all();
            end else begin
              note_or_rest(note_freq[note_idx]);
              ticks_left = note_len[note_idx];
            end
          end
        end
      end
      CMD_WRITE: begin
        note_freq[c.slot] = c.freq;
        note_len[c.slot] = c.dur;
      end
      CMD_START: begin
        if (c.len != 0) begin
          melody_len = (c.len > MAX_NOTES) ? LEN_W'(MAX_NOTES) : c.len;
          note_idx = '0;
          if (note_freq[0] != 0) begin
            tone_on(note_freq[0]);
          end else if (beep_left == 0) begin
            gate = 1'b0;
          end
          ticks_left = note_len[0];
          playing = 1'b1;
        end
      end
      CMD_STOP: silence_all();
      CMD_BEEP: begin
        tone_on(beep_freq_cfg);
        beep_left = beep_dur_cfg;
      end
      default: ;
    endcase
    st.speaker = gate;
    st.divisor = divisor;
    st.playing = playing;
    st.beeping = beep_left != 0;
    st.position = note_idx;
    return st;
  endfunction

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("status beat %0d field %s: got %0d, expected %0d",
                             results_out, name, got, want));
    end
  endtask

  // Input driver: presents queued commands, predicts each one as it is accepted.
  always @(posedge clk) begin
    bit fire;
    bit may_send;
    fire = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (fire) begin
        status_due_q.push_back(predict_status(cur_cmd));
        items_in <= items_in + 1;
      end
      if (!in_valid || fire) begin
        may_send = pending_cmd_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct;
        // A held beat waits until every status beat already owed has come back.
        if (may_send && pending_cmd_q[0].hold && (fire || items_in != results_out)) begin
          may_send = 1'b0;
        end
        if (may_send) begin
          cur_cmd = pending_cmd_q.pop_front();
          in_command <= cur_cmd.code;
          in_note_slot <= cur_cmd.slot;
          in_note_frequency <= cur_cmd.freq;
          in_note_duration <= cur_cmd.dur;
          in_melody_length <= cur_cmd.len;
        end
        in_valid <= may_send;
      end
    end
  end

  // Status monitor.
  always @(posedge clk) begin
    tone_status_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_out == items_in) begin
          report_error($sformatf("status beat with nothing outstanding (divisor %0d)",
                                 out_tone_divisor));
        end else begin
          want = status_due_q.pop_front();
          check_field("speaker_on", out_speaker_on, want.speaker);
          check_field("tone_divisor", out_tone_divisor, want.divisor);
          check_field("melody_playing", out_melody_playing, want.playing);
          check_field("beep_active", out_beep_active, want.beeping);
          check_field("note_position", out_note_position, want.position);
          results_out <= results_out + 1;
        end
      end
      out_stall <= $urandom_range(0, 99) < rcv_stall_pct;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_NOTES && slot_written[n]) n++;
    return n;
  endfunction

  // Start lengths only ever cover slots that hold a note.
  function automatic int pick_length();
    int n;
    n = written_prefix();
    if (n == 0) return 0;
    if (n == MAX_NOTES && $urandom_range(0, 3) == 0) return $urandom_range(MAX_NOTES, LEN_MAX);
    if ($urandom_range(0, 3) != 0) return $urandom_range(1, (n < 6) ? n : 6);
    return $urandom_range(1, n);
  endfunction

  function automatic int pick_freq();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r == 2) return 1;
    if (r == 3) return FREQ_MAX;
    return $urandom_range(1, FREQ_MAX);
  endfunction

  function automatic int pick_dur();
    return ($urandom_range(0, 6) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 12);
  endfunction

  function automatic int pick_notes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, MAX_NOTES);
  endfunction

  task automatic push_cmd(input logic [2:0] code, input int slot, input int freq,
                          input int dur, input int len, input bit hold = 1'b0);
    seq_cmd_t c;
    c.code = code;
    c.slot = slot[NOTE_AW-1:0];
    c.freq = freq[FREQ_W-1:0];
    c.dur = dur[DUR_W-1:0];
    c.len = len[LEN_W-1:0];
    c.hold = hold;
    if (code == CMD_WRITE) slot_written[c.slot] = 1'b1;
    if (code <= CMD_BEEP && !(code == CMD_START && c.len == 0)) phase_items++;
    pending_cmd_q.push_back(c);
  endtask

  // Any command but start, with every field it does not use randomized.
  task automatic push_op(input logic [2:0] code, input bit hold = 1'b0);
    push_cmd(code, $urandom_range(0, MAX_NOTES - 1), $urandom_range(0, FREQ_MAX),
             $urandom_range(0, FREQ_MAX), $urandom_range(0, LEN_MAX), hold);
  endtask

  task automatic push_unknown();
    push_op(3'($urandom_range(CMD_BEEP + 1, CMD_CODE_MAX)));
  endtask

  // Fill slots 0..n-1, start the melody, then send ticks mixed with other commands.
  task automatic run_melody(input int n, input bit hold);
    int total;
    int d;
    int r;
    total = 0;
    for (int i = 0; i < n; i++) begin
      d = pick_dur();
      push_cmd(CMD_WRITE, i, pick_freq(), d, $urandom_range(0, LEN_MAX), hold && i == 0);
      total += d + 1;
    end
    push_cmd(CMD_START, $urandom_range(0, MAX_NOTES - 1), $urandom_range(0, FREQ_MAX),
             $urandom_range(0, FREQ_MAX),
             (n == MAX_NOTES && $urandom_range(0, 1) == 0) ?
               $urandom_range(MAX_NOTES, LEN_MAX) : n);
    for (int t = 0; t < total + 2; t++) begin
      r = $urandom_range(0, 99);
      if (r < 6) push_op(CMD_BEEP);
      else if (r < 8) push_op(CMD_STOP);
      else if (r < 10) push_op(CMD_WRITE);
      else if (r < 12) push_unknown();
      else push_op(CMD_TICK);
    end
  endtask

  task automatic beep_burst();
    int k;
    int r;
    push_op(CMD_BEEP);
    k = $urandom_range(0, (beep_dur_cfg + 1 < 12) ? beep_dur_cfg + 1 : 12);
    for (int t = 0; t < k; t++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_cmd(CMD_START, $urandom_range(0, MAX_NOTES - 1), $urandom_range(0, FREQ_MAX),
                 $urandom_range(0, FREQ_MAX), pick_length());
      end else if (r < 15) begin
        push_op(CMD_STOP);
      end else begin
        push_op(CMD_TICK);
      end
    end
  endtask

  task automatic noise_burst();
    logic [2:0] code;
    repeat ($urandom_range(1, 6)) begin
      code = 3'($urandom_range(0, CMD_CODE_MAX));
      if (code == CMD_START) begin
        push_cmd(CMD_START, $urandom_range(0, MAX_NOTES - 1), $urandom_range(0, FREQ_MAX),
                 $urandom_range(0, FREQ_MAX), pick_length());
      end else begin
        push_op(code);
      end
    end
  endtask

  // Poll on the falling edge so that every update of the rising edge has landed.
  task automatic settle_idle();
    while (pending_cmd_q.size() != 0 || in_valid || items_in != results_out) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [FREQ_W-1:0] f, input logic [BDUR_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_BEEP_FREQ;
    cfg_data <= f;
    @(posedge clk);
    cfg_index <= REG_BEEP_DUR;
    cfg_data <= 16'(($urandom_range(0, 255) << BDUR_W) | d);
    @(posedge clk);
    cfg_we <= 1'b0;
    beep_freq_cfg = f;
    beep_dur_cfg = d;
  endtask

  initial begin
    logic [FREQ_W-1:0] f;
    logic [BDUR_W-1:0] d;
    int r;
    bit first;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Idle commands, ignored commands and field extremes at reset settings.
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_STOP, MAX_NOTES - 1, FREQ_MAX, FREQ_MAX, LEN_MAX);
    push_cmd(CMD_START, 0, 0, 0, 0);
    push_cmd(3'(CMD_BEEP + 1), MAX_NOTES - 1, FREQ_MAX, FREQ_MAX, LEN_MAX);
    push_cmd(3'(CMD_CODE_MAX), 0, 0, 0, 0);
    push_cmd(CMD_WRITE, 0, 0, 0, 0);
    push_cmd(CMD_WRITE, 1, 1, 1, 0);
    push_cmd(CMD_WRITE, 2, FREQ_MAX, 0, 0);
    push_cmd(CMD_WRITE, MAX_NOTES - 1, FREQ_MAX, FREQ_MAX, LEN_MAX);
    // The melody opens on a rest; a beep over it must end in silence, not the beep tone.
    push_cmd(CMD_START, 0, 0, 0, 3);
    push_cmd(CMD_BEEP, 0, 0, 0, 0);
    repeat (3) push_cmd(CMD_TICK, 0, 0, 0, 0);
    repeat (4) push_cmd(CMD_TICK, 0, 0, 0, 0);
    // Start and stop while a beep is sounding.
    push_cmd(CMD_BEEP, 0, 0, 0, 0);
    push_cmd(CMD_START, 0, 0, 0, 3);
    push_cmd(CMD_STOP, 0, 0, 0, 0);
    repeat (3) push_cmd(CMD_TICK, 0, 0, 0, 0);

    // A zero beep frequency leaves the tone alone and a zero length never counts down.
    settle_idle();
    write_cfg('0, '0);
    push_cmd(CMD_BEEP, 0, 0, 0, 0);
    push_cmd(CMD_START, 0, 0, 0, 2);
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_STOP, 0, 0, 0, 0);

    settle_idle();
    write_cfg('1, '0);
    push_cmd(CMD_BEEP, 0, 0, 0, 0);
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_START, 0, 0, 0, 3);
    push_cmd(CMD_BEEP, 0, 0, 0, 0);
    push_cmd(CMD_TICK, 0, 0, 0, 0);
    push_cmd(CMD_STOP, 0, 0, 0, 0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      settle_idle();
      case (p)
        0: begin f = BEEP_FREQ_RST; d = BEEP_DUR_RST; snd_idle_pct = 0; rcv_stall_pct = 0; end
        1: begin f = 1; d = 1; snd_idle_pct = IDLE_HEAVY; rcv_stall_pct = 0; end
        2: begin f = '1; d = '1; snd_idle_pct = 0; rcv_stall_pct = IDLE_HEAVY; end
        3: begin
          f = FREQ_W'($urandom_range(1, FREQ_MAX));
          d = BDUR_W'($urandom_range(1, 255));
          snd_idle_pct = IDLE_LIGHT;
          rcv_stall_pct = IDLE_LIGHT;
        end
        4: begin f = 440; d = 6; snd_idle_pct = IDLE_HEAVY; rcv_stall_pct = 0; end
        default: begin
          f = FREQ_W'($urandom_range(0, FREQ_MAX));
          d = BDUR_W'($urandom_range(0, 255));
          snd_idle_pct = 0;
          rcv_stall_pct = IDLE_HEAVY;
        end
      endcase
      write_cfg(f, d);
      phase_items = 0;
      first = 1'b1;
      while (phase_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        // The first phase fills the whole table so that long lengths become legal.
        if (first) run_melody((p == 0) ? MAX_NOTES : pick_notes(), 1'b1);
        else if (r < 50) run_melody(pick_notes(), $urandom_range(0, 19) == 0);
        else if (r < 75) beep_burst();
        else noise_burst();
        first = 1'b0;
      end
    end

    settle_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
